>>> src/fir_convolver_core_assert.svh
// Assertion macros for the FIR convolver core.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef FIR_CONVOLVER_CORE_ASSERT_SVH
`define FIR_CONVOLVER_CORE_ASSERT_SVH

// same-cycle implication
`define FCV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcv assertion failed");

// next-cycle implication
`define FCV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcv assertion failed");

`endif

>>> src/fcv_pkg.sv
// Shared constants and types for the FIR convolver core.
// No dependencies.
`default_nettype none
package fcv_pkg;

  localparam int TAPS        = 256;
  localparam int TAP_BITS    = $clog2(TAPS);
  localparam int CNT_BITS    = TAP_BITS + 1;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int ACC_W       = PROD_W + TAP_BITS;

  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 32;
  localparam logic REG_TAP_COUNT = 1'b0;

  localparam logic REQ_FILTER = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic rd_valid;
  } mac_ctl_t;

endpackage
`default_nettype wire

>>> src/fir_convolver_core.sv
// Top level of the FIR convolver core: sequencer, coefficient and delay memories.
// Depends on fcv_pkg, fcv_mac and fir_convolver_core_assert.svh.
`default_nettype none
// Direct-form FIR filter, Q1.15 in and out. A filter beat writes its sample
// into a 256-entry circular delay line and returns one rounded, saturated
// output; a load beat writes one coefficient, clears the delay line and
// returns nothing. One multiply-accumulate per tap per cycle: with taps being
// tap_count capped at 256, a filter beat holds off the next beat while it is
// taken, one memory read per tap is issued, the read and multiply pipeline
// drains (no read with tap_count zero) and the output register is loaded.
// A load beat is taken without leaving the idle state. The finished output
// waits in its own register, so the next beat is taken while it is stalled.
// The delay line is cleared at once by per-entry valid bits; coefficients
// read before being written are undefined.
module fir_convolver_core (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire                                   req_type,
  input  wire logic signed [15:0]               sample_in,
  input  wire logic        [7:0]                coef_index,
  input  wire logic signed [15:0]               coef_value,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [15:0]                    filtered_sample,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire logic [fcv_pkg::ADDR_BITS-1:0]    paddr,
  input  wire logic [fcv_pkg::DATA_BITS-1:0]    pwdata,
  output logic [fcv_pkg::DATA_BITS-1:0]         prdata,
  output logic                                  pready
);
  import fcv_pkg::*;

  state_t                        state;
  state_t                        state_next;
  logic [CNT_BITS-1:0]           tap_count;
  logic [CNT_BITS-1:0]           taps_eff;
  logic [CNT_BITS-1:0]           k;
  logic [TAP_BITS-1:0]           wp;
  logic [TAP_BITS-1:0]           cur;
  logic [TAP_BITS-1:0]           dly_addr;

  logic signed [SAMPLE_BITS-1:0] coef_mem [TAPS];
  logic signed [SAMPLE_BITS-1:0] dly_mem  [TAPS];
  logic [TAPS-1:0]               dvalid;

  logic signed [SAMPLE_BITS-1:0] coef_q;
  logic signed [SAMPLE_BITS-1:0] dly_q;
  logic                          dvld_q;
  logic                          rd_v;

  logic                          accept;
  logic                          accept_smp;
  logic                          accept_load;
  logic                          issue;
  logic                          load_out;
  logic                          mac_busy;
  logic signed [SAMPLE_BITS-1:0] mac_result;
  mac_ctl_t                      mac_ctl;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= CNT_BITS'(1);
    end else if (psel && penable && pwrite && paddr[2] == REG_TAP_COUNT) begin
      tap_count <= pwdata[CNT_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TAP_COUNT) begin
      prdata = DATA_BITS'(tap_count);
    end
  end

  assign taps_eff = (tap_count > CNT_BITS'(TAPS)) ? CNT_BITS'(TAPS) : tap_count;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept_smp) begin
          state_next = (taps_eff == '0) ? S_DRAIN : S_RUN;
        end
      end
      S_RUN: begin
        if (k + CNT_BITS'(1) == taps_eff) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_v && !mac_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state)
      S_IDLE:  in_stall = 1'b0;
      S_RUN:   issue    = 1'b1;
      S_DRAIN: in_stall = 1'b1;
      S_DONE:  load_out = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign accept      = in_valid && !in_stall;
  assign accept_smp  = accept && req_type == REQ_FILTER;
  assign accept_load = accept && req_type == REQ_LOAD;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wp    <= '0;
      k     <= '0;
      rd_v  <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= issue;
      if (accept_load) begin
        wp <= '0;
      end else if (accept_smp) begin
        wp <= wp + TAP_BITS'(1);
      end
      if (accept_smp) begin
        k <= '0;
      end else if (issue) begin
        k <= k + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_smp) begin
      cur <= wp;
    end
  end

  // delay valid bits: cleared by reset and by a coefficient load
  always_ff @(posedge clk) begin
    if (rst || accept_load) begin
      dvalid <= '0;
    end else if (accept_smp) begin
      dvalid[wp] <= 1'b1;
    end
  end

  assign dly_addr = cur - k[TAP_BITS-1:0];

  always_ff @(posedge clk) begin
    if (accept_smp) begin
      dly_mem[wp] <= sample_in;
    end
    if (issue) begin
      dly_q  <= dly_mem[dly_addr];
      dvld_q <= dvalid[dly_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept_load && {1'b0, coef_index} < 9'(TAPS)) begin
      coef_mem[coef_index[TAP_BITS-1:0]] <= coef_value;
    end
    if (issue) begin
      coef_q <= coef_mem[k[TAP_BITS-1:0]];
    end
  end

  assign mac_ctl.clear    = accept_smp;
  assign mac_ctl.rd_valid = rd_v;

  fcv_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctl        (mac_ctl),
    .coef       (coef_q),
    .sample     (dly_q),
    .sample_vld (dvld_q),
    .busy       (mac_busy),
    .result     (mac_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered_sample <= mac_result;
    end
  end

  `include "fir_convolver_core_assert.svh"

  `FCV_ASSERT_NEXT(a_smp_busy, accept_smp, in_stall)
  `FCV_ASSERT_NEXT(a_load_clears, accept_load, dvalid == '0 && wp == '0)
  `FCV_ASSERT_NOW(a_done_drained, state == S_DONE, !rd_v && !mac_busy)
  `FCV_ASSERT_NOW(a_k_in_range, state == S_RUN, k < taps_eff)

endmodule
`default_nettype wire

>>> src/fcv_mac.sv
// Multiply-accumulate datapath with rounding and saturation to the sample format.
// Depends on fcv_pkg.
`default_nettype none
module fcv_mac (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire fcv_pkg::mac_ctl_t                 ctl,
  input  wire logic signed [fcv_pkg::SAMPLE_BITS-1:0] coef,
  input  wire logic signed [fcv_pkg::SAMPLE_BITS-1:0] sample,
  input  wire                                    sample_vld,
  output logic                                   busy,
  output logic signed [fcv_pkg::SAMPLE_BITS-1:0] result
);
  import fcv_pkg::*;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] SAT_LIM  = ACC_W'(64'sd1 <<< (2 * FRAC_BITS));
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] x_eff;
  logic signed [PROD_W-1:0]      prod;
  logic                          prod_v;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       rounded;
  logic signed [ACC_W-1:0]       shifted;

  // a delay entry not written since the last clear reads as zero
  assign x_eff = sample_vld ? sample : '0;

  always_ff @(posedge clk) begin
    prod <= coef * x_eff;
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign busy    = prod_v;
  assign rounded = acc + RND_HALF;
  assign shifted = rounded >>> FRAC_BITS;

  always_comb begin
    if (acc >= SAT_LIM - RND_HALF) begin
      result = OUT_MAX;
    end else if (acc < -SAT_LIM - RND_HALF) begin
      result = OUT_MIN;
    end else begin
      result = shifted[SAMPLE_BITS-1:0];
    end
  end

endmodule
`default_nettype wire
